// ===== src/kprf_pkg.sv =====
// ----------------------------------------------------------------------------
// kprf_pkg: shared types and constants of the key press repeat unit.
// Phase and event codes, configuration indexes and controller interface.
// ----------------------------------------------------------------------------
package kprf_pkg;

  localparam int NumKeysDef = 4;
  localparam int MaskW      = 4;
  localparam int CodeW      = 8;
  localparam int DelayW     = 8;
  localparam int CodesW     = 32;
  localparam int CntW       = 9;
  localparam int MaxEvents  = 4;
  localparam int EvIdxW     = 2;
  localparam int EvCntW     = 3;
  localparam int CfgIdxW    = 2;

  localparam logic [CntW-1:0]   CntMax          = 9'd511;
  localparam logic [DelayW-1:0] FirstDelayReset = 8'd30;
  localparam logic [DelayW-1:0] RepeatDelayReset = 8'd20;
  localparam logic [DelayW-1:0] DoubleHitReset  = 8'd10;
  localparam logic [CodesW-1:0] KeyCodesReset   = 32'h0F0E0B0A;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_FIRST_DELAY  = 2'd0,
    CFG_REPEAT_DELAY = 2'd1,
    CFG_DOUBLE_HIT   = 2'd2,
    CFG_KEY_CODES    = 2'd3
  } cfg_idx_e;

  typedef enum logic [2:0] {
    PH_IDLE = 3'd0,
    PH_CAND = 3'd1,
    PH_HELD = 3'd2,
    PH_REPT = 3'd3,
    PH_LOCK = 3'd4
  } phase_e;

  typedef enum logic [1:0] {
    EV_PRESS   = 2'd0,
    EV_LONG    = 2'd1,
    EV_RELEASE = 2'd2
  } event_e;

  typedef enum logic [1:0] {
    ST_IDLE  = 2'd0,
    ST_SCAN  = 2'd1,
    ST_DRAIN = 2'd2
  } ctrl_state_e;

  typedef struct packed {
    logic              accept;
    logic              scan;
    logic              drain;
    logic [EvIdxW-1:0] rd_idx;
  } cmd_t;

  typedef struct packed {
    logic [EvCntW-1:0] ev_cnt;
    logic              out_free;
  } status_t;

endpackage

// ===== src/kprf_ctrl.sv =====
// ----------------------------------------------------------------------------
// kprf_ctrl: sequencing controller of the key press repeat unit.
// Accepts one scan tick, visits one key per cycle, then drains the events.
// ----------------------------------------------------------------------------
module kprf_ctrl #(
  parameter int NUM_KEYS = kprf_pkg::NumKeysDef,
  parameter int KeyW     = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  kprf_pkg::status_t status_i,
  output kprf_pkg::cmd_t    cmd_o,
  output logic [KeyW-1:0]   key_idx_o
);
  import kprf_pkg::*;

  localparam logic [KeyW-1:0] LastKey = KeyW'(NUM_KEYS - 1);

  ctrl_state_e       state_q, state_d;
  logic [KeyW-1:0]   key_q, key_d;
  logic [EvIdxW-1:0] rd_q, rd_d;
  logic              last_rd;

  assign last_rd = ({1'b0, rd_q} + 3'd1) == status_i.ev_cnt;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (key_q == LastKey) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (status_i.ev_cnt == '0) begin
          state_d = ST_IDLE;
        end else if (status_i.out_free && last_rd) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o        = '0;
    cmd_o.rd_idx = rd_q;
    in_stall_o   = 1'b1;
    key_d        = key_q;
    rd_d         = rd_q;
    case (state_q)
      ST_IDLE: begin
        in_stall_o   = 1'b0;
        cmd_o.accept = in_valid_i;
        key_d        = '0;
        rd_d         = '0;
      end
      ST_SCAN: begin
        cmd_o.scan = 1'b1;
        key_d      = key_q + 1'b1;
      end
      ST_DRAIN: begin
        if (status_i.ev_cnt != '0 && status_i.out_free) begin
          cmd_o.drain = 1'b1;
          rd_d        = rd_q + 1'b1;
        end
      end
      default: begin
        in_stall_o = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      key_q   <= '0;
      rd_q    <= '0;
    end else begin
      state_q <= state_d;
      key_q   <= key_d;
      rd_q    <= rd_d;
    end
  end

  assign key_idx_o = key_q;

endmodule

// ===== src/kprf_dp.sv =====
// ----------------------------------------------------------------------------
// kprf_dp: datapath of the key press repeat unit.
// Holds configuration, per-key phase and counter, event buffer and output.
// ----------------------------------------------------------------------------
module kprf_dp #(
  parameter int NUM_KEYS = kprf_pkg::NumKeysDef,
  parameter int KeyW     = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [kprf_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [kprf_pkg::CodesW-1:0]   cfg_data_i,
  input  logic [kprf_pkg::MaskW-1:0]    pressed_mask_i,
  input  kprf_pkg::cmd_t                cmd_i,
  input  logic [KeyW-1:0]               key_idx_i,
  output kprf_pkg::status_t             status_o,
  input  logic                          out_stall_i,
  output logic                          out_valid_o,
  output logic [kprf_pkg::CodeW-1:0]    key_code_o,
  output logic [1:0]                    event_kind_o,
  output logic                          last_event_o
);
  import kprf_pkg::*;

  logic [DelayW-1:0] first_delay_q, repeat_delay_q, double_hit_q;
  logic [CodesW-1:0] key_codes_q;
  logic [MaskW-1:0]  mask_q;

  phase_e            phase_q [NUM_KEYS];
  logic [CntW-1:0]   cnt_q   [NUM_KEYS];

  logic [CodeW-1:0]  buf_code_q [MaxEvents];
  event_e            buf_kind_q [MaxEvents];
  logic [EvCntW-1:0] ev_cnt_q;

  logic              out_valid_q;
  logic [CodeW-1:0]  out_code_q;
  event_e            out_kind_q;
  logic              out_last_q;

  logic [3:0]        key4;
  logic              down;
  logic [CodeW-1:0]  code_cur;
  phase_e            ph_cur, ph_nxt;
  logic [CntW-1:0]   cnt_cur, cnt_nxt, cnt_inc;
  logic [DelayW-1:0] limit;
  logic              ev_hit;
  event_e            ev_kind;

  assign key4     = 4'(key_idx_i);
  assign down     = (key4 < 4'd4) && mask_q[key4[1:0]];
  assign code_cur = (key4 < 4'd4) ? key_codes_q[key4[1:0]*CodeW +: CodeW] : '0;
  assign ph_cur   = phase_q[key_idx_i];
  assign cnt_cur  = cnt_q[key_idx_i];
  assign cnt_inc  = (cnt_cur == CntMax) ? cnt_cur : cnt_cur + 9'd1;
  assign limit    = (ph_cur == PH_HELD) ? first_delay_q : repeat_delay_q;

  always_comb begin
    ph_nxt  = ph_cur;
    cnt_nxt = cnt_cur;
    ev_hit  = 1'b0;
    ev_kind = EV_PRESS;
    case (ph_cur)
      PH_IDLE: begin
        if (down) begin
          ph_nxt = PH_CAND;
        end
      end
      PH_CAND: begin
        ev_hit = 1'b1;
        if (down) begin
          ph_nxt  = PH_HELD;
          cnt_nxt = '0;
          ev_kind = EV_PRESS;
        end else begin
          ph_nxt  = PH_IDLE;
          ev_kind = EV_RELEASE;
        end
      end
      PH_HELD, PH_REPT: begin
        if (down) begin
          if (cnt_cur >= {1'b0, limit}) begin
            ph_nxt  = PH_REPT;
            cnt_nxt = '0;
            ev_hit  = 1'b1;
            ev_kind = EV_LONG;
          end else begin
            cnt_nxt = cnt_inc;
          end
        end else begin
          ph_nxt  = PH_LOCK;
          cnt_nxt = '0;
          ev_hit  = 1'b1;
          ev_kind = EV_RELEASE;
        end
      end
      PH_LOCK: begin
        if (cnt_cur < {1'b0, double_hit_q}) begin
          cnt_nxt = cnt_inc;
        end else begin
          ph_nxt = PH_IDLE;
        end
      end
      default: ph_nxt = PH_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_delay_q  <= FirstDelayReset;
      repeat_delay_q <= RepeatDelayReset;
      double_hit_q   <= DoubleHitReset;
      key_codes_q    <= KeyCodesReset;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_FIRST_DELAY:  first_delay_q  <= cfg_data_i[DelayW-1:0];
        CFG_REPEAT_DELAY: repeat_delay_q <= cfg_data_i[DelayW-1:0];
        CFG_DOUBLE_HIT:   double_hit_q   <= cfg_data_i[DelayW-1:0];
        CFG_KEY_CODES:    key_codes_q    <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      mask_q <= pressed_mask_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < NUM_KEYS; k++) begin
        phase_q[k] <= PH_IDLE;
        cnt_q[k]   <= '0;
      end
    end else if (cmd_i.scan) begin
      phase_q[key_idx_i] <= ph_nxt;
      cnt_q[key_idx_i]   <= cnt_nxt;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ev_cnt_q <= '0;
    end else if (cmd_i.accept) begin
      ev_cnt_q <= '0;
    end else if (cmd_i.scan && ev_hit && ev_cnt_q < EvCntW'(MaxEvents)) begin
      ev_cnt_q <= ev_cnt_q + 3'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.scan && ev_hit && ev_cnt_q < EvCntW'(MaxEvents)) begin
      buf_code_q[ev_cnt_q[EvIdxW-1:0]] <= code_cur;
      buf_kind_q[ev_cnt_q[EvIdxW-1:0]] <= ev_kind;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.drain) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.drain) begin
      out_code_q <= buf_code_q[cmd_i.rd_idx];
      out_kind_q <= buf_kind_q[cmd_i.rd_idx];
      out_last_q <= ({1'b0, cmd_i.rd_idx} + 3'd1) == ev_cnt_q;
    end
  end

  assign status_o.ev_cnt   = ev_cnt_q;
  assign status_o.out_free = !out_valid_q || !out_stall_i;

  assign out_valid_o  = out_valid_q;
  assign key_code_o   = out_code_q;
  assign event_kind_o = out_kind_q;
  assign last_event_o = out_last_q;

endmodule

// ===== src/key_press_repeat_fsm_unit.sv =====
// ----------------------------------------------------------------------------
// key_press_repeat_fsm_unit: key press, long-press and auto-repeat detector.
// Each accepted transfer is one scan tick with the pressed level of every
// key. The unit then visits one key per cycle, stepping that key's phase
// and tick counter, and collects up to four events in a small buffer. It
// then sends the events in key order, one per cycle while the output is
// not stalled, the final one marked by last_event_o. The controller
// visits the single key-update datapath; a new tick is taken once the
// last event sits in the output register. Configuration writes take
// effect at once and are meant for idle periods.
// ----------------------------------------------------------------------------
module key_press_repeat_fsm_unit #(
  parameter int NUM_KEYS = kprf_pkg::NumKeysDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [kprf_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [kprf_pkg::CodesW-1:0]   cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [kprf_pkg::MaskW-1:0]    pressed_mask_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [kprf_pkg::CodeW-1:0]    key_code_o,
  output logic [1:0]                    event_kind_o,
  output logic                          last_event_o
);
  import kprf_pkg::*;

  localparam int KeyW = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;

  cmd_t            cmd;
  status_t         status;
  logic [KeyW-1:0] key_idx;

  kprf_ctrl #(
    .NUM_KEYS (NUM_KEYS),
    .KeyW     (KeyW)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .cmd_o      (cmd),
    .key_idx_o  (key_idx)
  );

  kprf_dp #(
    .NUM_KEYS (NUM_KEYS),
    .KeyW     (KeyW)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .pressed_mask_i (pressed_mask_i),
    .cmd_i          (cmd),
    .key_idx_i      (key_idx),
    .status_o       (status),
    .out_stall_i    (out_stall_i),
    .out_valid_o    (out_valid_o),
    .key_code_o     (key_code_o),
    .event_kind_o   (event_kind_o),
    .last_event_o   (last_event_o)
  );

  a_ev_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    status.ev_cnt <= EvCntW'(MaxEvents))
    else $error("event count exceeds buffer depth");

  a_drain_has_entry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.drain |-> ({1'b0, cmd.rd_idx} < status.ev_cnt))
    else $error("drain of an empty buffer entry");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("input not stalled while a tick is in progress");

  a_drain_output_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.drain |-> (!out_valid_o || !out_stall_i))
    else $error("output register overwritten while stalled");

endmodule
